[rtl/bec_pkg.sv]
`default_nettype none

package bec_pkg;

    localparam int BUTTON_COUNT = 4;
    localparam int COUNT_WIDTH  = 16;
    localparam int CFG_BUTTONS  = 4;
    localparam int PIN_COUNT    = 4;
    localparam int TIME_WIDTH   = 16;
    localparam int MODE_WIDTH   = 2;
    localparam int IDX_WIDTH    = 2;
    localparam int CFG_DATA_W   = 64;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [3:0]             ev_t;

    localparam count_t COUNT_MAX = '1;

    // event flag bit positions
    localparam int EV_PRESSED  = 0;
    localparam int EV_TAP      = 1;
    localparam int EV_RELEASED = 2;
    localparam int EV_LONG     = 3;

    typedef enum logic [2:0] {
        REQ_TICK     = 3'd0,
        REQ_PRESSED  = 3'd1,
        REQ_TAP      = 3'd2,
        REQ_RELEASED = 3'd3,
        REQ_LONG     = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        MODE_PLAIN  = 2'd0,
        MODE_LONG   = 2'd1,
        MODE_REPEAT = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        CFG_ENABLE       = 2'd0,
        CFG_MODES        = 2'd1,
        CFG_LONG_TIMES   = 2'd2,
        CFG_REPEAT_TIMES = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic                  tick;
        logic                  down;
        logic [MODE_WIDTH-1:0] mode;
        count_t                long_t;
        count_t                rep_t;
        ev_t                   clr;
    } btn_ctrl_t;

    function automatic count_t to_count(input logic [TIME_WIDTH-1:0] v);
        return count_t'(v);
    endfunction

endpackage

`default_nettype wire

[rtl/bec_button.sv]
`default_nettype none

module bec_button
    import bec_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire btn_ctrl_t ctrl,
    output ev_t            flags
);

    count_t count_reg;
    count_t count_next;
    logic   held_reg;
    logic   held_next;
    ev_t    flags_reg;
    ev_t    flags_next;

    count_t count_inc;
    logic   sat;
    logic   long_hit;
    logic   rep_hit;

    assign count_inc = count_t'(count_reg + 1'b1);
    assign sat       = (count_reg == COUNT_MAX);
    assign long_hit  = (ctrl.mode == MODE_LONG) && !sat && (ctrl.long_t != '0) &&
                       (count_inc == ctrl.long_t);
    assign rep_hit   = (ctrl.mode == MODE_REPEAT) && !sat && (ctrl.rep_t != '0) &&
                       (count_inc == ctrl.rep_t);

    always_comb
    begin
        count_next = count_reg;
        held_next  = held_reg;
        flags_next = flags_reg & ~ctrl.clr;
        if (ctrl.tick)
        begin
            if (held_reg && !ctrl.down)
            begin
                // release edge
                flags_next[EV_TAP]      = (count_reg < ctrl.long_t);
                flags_next[EV_RELEASED] = 1'b1;
                flags_next[EV_PRESSED]  = 1'b0;
                count_next              = '0;
                held_next               = 1'b0;
            end
            else if (ctrl.down)
            begin
                if ((ctrl.mode == MODE_LONG || ctrl.mode == MODE_REPEAT) && !sat)
                begin
                    count_next = count_inc;
                end
                if (long_hit)
                begin
                    flags_next[EV_LONG] = 1'b1;
                end
                else if (rep_hit)
                begin
                    flags_next[EV_PRESSED] = 1'b1;
                    count_next             = '0;
                end
                else if (!held_reg)
                begin
                    flags_next[EV_RELEASED] = 1'b0;
                    flags_next[EV_PRESSED]  = 1'b1;
                    held_next               = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            held_reg  <= 1'b0;
            flags_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            held_reg  <= held_next;
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule

`default_nettype wire

[rtl/button_event_classifier_core.sv]
`default_nettype none

// channel  signals                                   direction  accepted when
// in       req_type, pin_levels, button_index        input      in_valid & in_ready
// out      flag                                      output     out_valid & out_ready
// cfg      cfg_index, cfg_data                       input      cfg_valid & cfg_ready
//
// One item per cycle sustained while out_ready stays high; an item passes from accept to flag
// through the input register, then updates the button state into the result register.
// All button state changes when an item leaves the input register, so results keep order.
// in_ready drops only while the result register is full and out_ready is low.
// rst_n clears configuration, counters, held and event flags; cfg is always ready.

module button_event_classifier_core
    import bec_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [2:0]            req_type,
    input  wire logic [PIN_COUNT-1:0]  pin_levels,
    input  wire logic [IDX_WIDTH-1:0]  button_index,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       flag,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CFG_BUTTONS-1:0]              enable_reg;
    logic [MODE_WIDTH*CFG_BUTTONS-1:0]   modes_reg;
    logic [TIME_WIDTH*CFG_BUTTONS-1:0]   long_times_reg;
    logic [TIME_WIDTH*CFG_BUTTONS-1:0]   repeat_times_reg;

    logic                 s1_valid_reg;
    logic [2:0]           s1_req_reg;
    logic [PIN_COUNT-1:0] s1_pins_reg;
    logic [IDX_WIDTH-1:0] s1_idx_reg;

    logic out_valid_reg;
    logic flag_reg;
    logic flag_next;
    logic suppress_reg;
    logic suppress_next;

    logic                    advance;
    logic                    is_tick;
    ev_t                     qmask;
    logic [BUTTON_COUNT-1:0] hit;

    assign cfg_ready = 1'b1;
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg       <= '0;
            modes_reg        <= '0;
            long_times_reg   <= '0;
            repeat_times_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ENABLE:       enable_reg       <= cfg_data[CFG_BUTTONS-1:0];
                CFG_MODES:        modes_reg        <= cfg_data[MODE_WIDTH*CFG_BUTTONS-1:0];
                CFG_LONG_TIMES:   long_times_reg   <= cfg_data[TIME_WIDTH*CFG_BUTTONS-1:0];
                CFG_REPEAT_TIMES: repeat_times_reg <= cfg_data[TIME_WIDTH*CFG_BUTTONS-1:0];
                default:          enable_reg       <= enable_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_req_reg  <= req_type;
            s1_pins_reg <= pin_levels;
            s1_idx_reg  <= button_index;
        end
    end

    // request decode
    always_comb
    begin
        is_tick = 1'b0;
        qmask   = '0;
        unique case (req_t'(s1_req_reg))
            REQ_TICK:     is_tick = 1'b1;
            REQ_PRESSED:  qmask[EV_PRESSED] = 1'b1;
            REQ_TAP:      qmask[EV_TAP] = 1'b1;
            REQ_RELEASED:
            begin
                if (!suppress_reg)
                    qmask[EV_RELEASED] = 1'b1;
            end
            REQ_LONG:     qmask[EV_LONG] = 1'b1;
            default:      is_tick = 1'b0;
        endcase
    end

    always_comb
    begin
        suppress_next = suppress_reg;
        if (s1_req_reg == REQ_RELEASED && suppress_reg)
            suppress_next = 1'b0;
        else if (s1_req_reg == REQ_LONG && |hit)
            suppress_next = 1'b1;
        flag_next = |hit;
    end

    genvar i;
    generate
        for (i = 0; i < BUTTON_COUNT; i++)
        begin : g_btn
            logic                  en;
            logic                  sel;
            logic                  down;
            logic [MODE_WIDTH-1:0] mode;
            count_t                long_t;
            count_t                rep_t;
            btn_ctrl_t             ctrl;
            ev_t                   flags;

            if (i < CFG_BUTTONS)
            begin : g_cfg
                assign en     = enable_reg[i];
                assign mode   = modes_reg[MODE_WIDTH*i +: MODE_WIDTH];
                assign long_t = to_count(long_times_reg[TIME_WIDTH*i +: TIME_WIDTH]);
                assign rep_t  = to_count(repeat_times_reg[TIME_WIDTH*i +: TIME_WIDTH]);
            end
            else
            begin : g_nocfg
                assign en     = 1'b0;
                assign mode   = MODE_PLAIN;
                assign long_t = '0;
                assign rep_t  = '0;
            end

            if (i < PIN_COUNT)
            begin : g_pin
                assign down = !s1_pins_reg[i];
            end
            else
            begin : g_nopin
                assign down = 1'b1;
            end

            if (i < (1 << IDX_WIDTH))
            begin : g_sel
                assign sel = (s1_idx_reg == IDX_WIDTH'(i));
            end
            else
            begin : g_nosel
                assign sel = 1'b0;
            end

            always_comb
            begin
                ctrl.tick   = advance && is_tick && en;
                ctrl.down   = down;
                ctrl.mode   = mode;
                ctrl.long_t = long_t;
                ctrl.rep_t  = rep_t;
                ctrl.clr    = (advance && en && sel) ? qmask : '0;
            end

            assign hit[i] = en && sel && |(flags & qmask);

            bec_button u_button
            (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (ctrl),
                .flags (flags)
            );
        end
    endgenerate

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            suppress_reg  <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                suppress_reg  <= suppress_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            flag_reg <= flag_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign flag      = flag_reg;

endmodule

`default_nettype wire

[rtl/bec_checker.sv]
`default_nettype none

module bec_checker
    import bec_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_ready,
    input wire logic [2:0]           req_type,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic                 flag
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(flag))
        else $error("result changed while stalled");

    // input side stalls only behind a full, stalled result register
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled with free result register");

    // a result appearing from empty comes from an item accepted earlier through the input register
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without item");

    // ticks and unknown requests answer 0
    a_tick_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid) && $past(in_valid && in_ready, 2) &&
        ($past(req_type, 2) == REQ_TICK || $past(req_type, 2) > REQ_LONG) |-> !flag)
        else $error("tick item returned a set flag");

endmodule

bind button_event_classifier_core bec_checker u_bec_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .flag      (flag)
);

`default_nettype wire

[tb/button_event_classifier_core_test.sv]
`timescale 1ns / 100ps

module button_event_classifier_core_test;
    import bec_pkg::*;

    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam int         QUIET_LIMIT = 1000;
    localparam int         PHASES      = 8;
    localparam int         PHASE_ITEMS = 75;

    class button_scoreboard;
        logic [3:0]  enable_mask;
        logic [7:0]  modes;
        logic [63:0] long_times;
        logic [63:0] repeat_times;
        count_t      press_count[BUTTON_COUNT];
        bit          held[BUTTON_COUNT];
        ev_t         events[BUTTON_COUNT];
        bit          suppress_release;
        bit          pending_flags[$];
        int          errors;

        function new();
            enable_mask      = '0;
            modes            = '0;
            long_times       = '0;
            repeat_times     = '0;
            suppress_release = 1'b0;
            errors           = 0;
            for (int b = 0; b < BUTTON_COUNT; b++)
            begin
                press_count[b] = '0;
                held[b]        = 1'b0;
                events[b]      = '0;
            end
        endfunction

        function void write_reg(cfg_idx_t idx, logic [63:0] data);
            case (idx)
                CFG_ENABLE:       enable_mask  = data[3:0];
                CFG_MODES:        modes        = data[7:0];
                CFG_LONG_TIMES:   long_times   = data;
                CFG_REPEAT_TIMES: repeat_times = data;
                default: ;
            endcase
        endfunction

        // saturating count; true when the new count hits a nonzero target
        function bit bump_count(int b, count_t target);
            if (press_count[b] == COUNT_MAX)
                return 1'b0;
            press_count[b] = press_count[b] + 1'b1;
            return (target != '0) && (press_count[b] == target);
        endfunction

        function void tick_button(int b, bit down);
            logic [1:0] m;
            count_t     long_t;
            count_t     rep_t;
            m      = modes[2*b +: 2];
            long_t = count_t'(long_times[16*b +: 16]);
            rep_t  = count_t'(repeat_times[16*b +: 16]);
            if (held[b] && !down)
            begin
                events[b][EV_PRESSED]  = 1'b0;
                events[b][EV_TAP]      = (press_count[b] < long_t);
                events[b][EV_RELEASED] = 1'b1;
                press_count[b]         = '0;
                held[b]                = 1'b0;
            end
            else if (down)
            begin
                if (m == MODE_LONG && bump_count(b, long_t))
                    events[b][EV_LONG] = 1'b1;
                else if (m == MODE_REPEAT && bump_count(b, rep_t))
                begin
                    events[b][EV_PRESSED] = 1'b1;
                    press_count[b]        = '0;
                end
                else if (!held[b])
                begin
                    events[b][EV_RELEASED] = 1'b0;
                    events[b][EV_PRESSED]  = 1'b1;
                    held[b]                = 1'b1;
                end
            end
        endfunction

        function bit read_clear(int b, int pos);
            bit v;
            if (!enable_mask[b])
                return 1'b0;
            v              = events[b][pos];
            events[b][pos] = 1'b0;
            return v;
        endfunction

        function void note_input(logic [2:0] req, logic [3:0] pins, logic [1:0] idx);
            bit f;
            f = 1'b0;
            case (req)
                REQ_TICK:
                    for (int b = 0; b < BUTTON_COUNT; b++)
                        if (enable_mask[b])
                            tick_button(b, !pins[b]);
                REQ_PRESSED: f = read_clear(idx, EV_PRESSED);
                REQ_TAP:     f = read_clear(idx, EV_TAP);
                REQ_RELEASED:
                    if (suppress_release)
                        suppress_release = 1'b0;
                    else
                        f = read_clear(idx, EV_RELEASED);
                REQ_LONG:
                begin
                    f = read_clear(idx, EV_LONG);
                    if (f)
                        suppress_release = 1'b1;
                end
                default: ;
            endcase
            pending_flags.push_back(f);
        endfunction

        function void check_flag(logic actual);
            bit want;
            if (pending_flags.size() == 0)
            begin
                $error("flag: no item pending, got %0b", actual);
                errors++;
                return;
            end
            want = pending_flags.pop_front();
            if (actual !== want)
            begin
                $error("flag: expected %0b, got %0b", want, actual);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [2:0]            req_type;
    logic [PIN_COUNT-1:0]  pin_levels;
    logic [IDX_WIDTH-1:0]  button_index;
    logic                  out_valid;
    logic                  out_ready;
    logic                  flag;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [1:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bit                    idle_on;
    int                    quiet_cycles;
    button_scoreboard      sb = new();

    button_event_classifier_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .pin_levels   (pin_levels),
        .button_index (button_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .flag         (flag),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        out_ready <= !(idle_on && $urandom_range(99) < 14);

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_flag(flag);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("** button_event_classifier_core: FAILED **");
            $finish;
        end
    end

    task automatic send_item(logic [2:0] req, logic [3:0] pins, logic [1:0] idx);
        if (idle_on && $urandom_range(99) < 10)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= req;
        pin_levels   <= pins;
        button_index <= idx;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(req, pins, idx);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_flags.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic program_regs(logic [3:0] en, logic [7:0] m, logic [63:0] lt,
                                logic [63:0] rt);
        logic [63:0] vals[4];
        vals[CFG_ENABLE]       = 64'(en);
        vals[CFG_MODES]        = 64'(m);
        vals[CFG_LONG_TIMES]   = lt;
        vals[CFG_REPEAT_TIMES] = rt;
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            sb.write_reg(cfg_idx_t'(i), vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand_times();
        logic [63:0] t;
        int          r;
        for (int b = 0; b < CFG_BUTTONS; b++)
        begin
            r = $urandom_range(99);
            if (r < 10)
                t[16*b +: 16] = '0;
            else if (r < 15)
                t[16*b +: 16] = '1;
            else
                t[16*b +: 16] = 16'($urandom_range(6, 1));
        end
        return t;
    endfunction

    task automatic run_directed();
        // everything disabled out of reset
        send_item(REQ_TICK, 4'h0, 2'd0);
        send_item(REQ_PRESSED, 4'h0, 2'd0);
        drain();
        // button 0 plain, 1 long press, 2 auto repeat, 3 spare mode
        program_regs(4'hF, {MODE_SPARE, 2'(MODE_REPEAT), 2'(MODE_LONG), 2'(MODE_PLAIN)},
                     64'h0000_0000_0002_FFFF, 64'h0000_0002_0000_0000);
        send_item(REQ_TICK, 4'hF, 2'd0);
        send_item(REQ_TICK, 4'h0, 2'd1);
        send_item(REQ_TICK, 4'h0, 2'd2);
        for (int b = 0; b < BUTTON_COUNT; b++)
            send_item(REQ_PRESSED, 4'hF, 2'(b));
        // long read hides the next release read
        send_item(REQ_LONG, 4'hA, 2'd1);
        send_item(REQ_RELEASED, 4'h5, 2'd1);
        send_item(REQ_LONG, 4'h0, 2'd1);
        send_item(REQ_TICK, 4'hF, 2'd3);
        for (int b = 0; b < BUTTON_COUNT; b++)
            send_item(REQ_TAP, 4'h0, 2'(b));
        for (int b = 0; b < BUTTON_COUNT; b++)
            send_item(REQ_RELEASED, 4'h0, 2'(b));
        for (int u = 1; u <= 3; u++)
            send_item(3'(REQ_LONG) + 3'(u), 4'($urandom), 2'(u));
    endtask

    task automatic run_random_phases();
        logic [3:0]  en;
        logic [7:0]  m;
        logic [63:0] lt;
        logic [63:0] rt;
        logic [3:0]  pins_now;
        int          r;
        pins_now = 4'hF;
        for (int p = 0; p < PHASES; p++)
        begin
            en = '1;
            m  = 8'($urandom);
            lt = rand_times();
            rt = rand_times();
            case (p)
                0: en = '0;
                1:
                begin
                    m  = '1;
                    lt = '1;
                    rt = '1;
                end
                2: m = {4{2'(MODE_LONG)}};
                3:
                begin
                    m  = {4{2'(MODE_REPEAT)}};
                    lt = '0;
                    rt = '0;
                end
                default: en = 4'($urandom);
            endcase
            drain();
            idle_on = (p != 4);
            program_regs(en, m, lt, rt);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 2 && n == PHASE_ITEMS / 2)
                    drain();
                r = $urandom_range(99);
                if (r < 50)
                begin
                    if ($urandom_range(19) == 0)
                        pins_now = 4'($urandom);
                    else
                        for (int b = 0; b < PIN_COUNT; b++)
                            if ($urandom_range(99) < 15)
                                pins_now[b] = ~pins_now[b];
                    send_item(REQ_TICK, pins_now, 2'($urandom));
                end
                else if (r < 95)
                    send_item(3'($urandom_range(REQ_LONG, REQ_PRESSED)), 4'($urandom),
                              2'($urandom));
                else
                    send_item(3'(REQ_LONG) + 3'($urandom_range(3, 1)), 4'($urandom),
                              2'($urandom));
            end
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        req_type     = '0;
        pin_levels   = '0;
        button_index = '0;
        out_ready    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        idle_on      = 1'b1;
        quiet_cycles = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random_phases();
        drain();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending_flags.size() == 0)
            $display("** button_event_classifier_core: PASSED **");
        else
            $display("** button_event_classifier_core: FAILED **");
        $finish;
    end

endmodule

[button_event_classifier_core.f]
rtl/bec_pkg.sv
rtl/bec_button.sv
rtl/button_event_classifier_core.sv
rtl/bec_checker.sv
tb/button_event_classifier_core_test.sv
